>>> sv/assert_macros.svh
// Assertion macros shared by the parser modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property under synchronous reset.
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert an expression that holds at every edge out of reset.
`define CHK_INV(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

>>> sv/drp_pkg.sv
// Types and constants for the DNS response parser.
// No dependencies.
`default_nettype none
package drp_pkg;
  localparam int MaxPacketBytes = 512;
  localparam int OffW = $clog2(MaxPacketBytes + 1);
  localparam int QDepth = 4;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QNAME  = 4'd1;
  localparam logic [3:0] PH_QFIXED = 4'd2;
  localparam logic [3:0] PH_ALEN   = 4'd3;
  localparam logic [3:0] PH_ASKIP  = 4'd4;
  localparam logic [3:0] PH_APTR   = 4'd5;
  localparam logic [3:0] PH_AFIXED = 4'd6;
  localparam logic [3:0] PH_RDATA  = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;
  localparam logic [3:0] PH_DRAIN  = 4'd9;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_ID      = 4'd2;
  localparam logic [3:0] ST_RCODE   = 4'd3;
  localparam logic [3:0] ST_QCOUNT  = 4'd4;
  localparam logic [3:0] ST_QNAME   = 4'd5;
  localparam logic [3:0] ST_CLASS   = 4'd6;
  localparam logic [3:0] ST_TYPE    = 4'd7;
  localparam logic [3:0] ST_COUNT   = 4'd8;
  localparam logic [3:0] ST_TRUNC   = 4'd9;

  localparam logic [1:0] REG_ID    = 2'd0;
  localparam logic [1:0] REG_TYPE  = 2'd1;
  localparam logic [1:0] REG_MAXAN = 2'd2;

  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] TYPE_MX  = 16'd15;
  localparam logic [15:0] CLASS_IN = 16'd1;

  // Raw answer or status word passed from front to back.
  typedef struct packed {
    logic        is_status;
    logic [3:0]  status;
    logic [15:0] rtype;
    logic [31:0] ttl;
    logic [31:0] ip;
    logic [15:0] prio;
    logic [15:0] rdlen;
    logic [8:0]  pos;
  } rec_t;

  typedef struct packed {
    logic        is_status;
    logic [15:0] record_type;
    logic [31:0] time_to_live;
    logic [31:0] ipv4_address;
    logic [15:0] mx_priority;
    logic [8:0]  rdata_offset;
    logic [15:0] rdata_length;
    logic [3:0]  status;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

>>> sv/drp_front.sv
// Byte parser front end: walks the datagram and emits raw records.
// Depends on drp_pkg.
`default_nettype none
module drp_front import drp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_packet,
  input  wire logic [15:0] expected_id,
  input  wire logic [15:0] expected_type,
  input  wire logic [15:0] max_answers,
  output logic             rec_valid,
  output rec_t             rec_a,
  output logic             sts_valid,
  output rec_t             rec_s
);
  logic [OffW-1:0] byte_offset;
  logic [3:0]  parse_phase;
  logic [31:0] field_shift;
  logic [15:0] skip_count, answers_left, cur_type, cur_rdlen, cur_prio;
  logic [3:0]  error_code;
  logic [31:0] cur_ttl, cur_ip;

  logic [OffW-1:0] off_n;
  logic [3:0]  ph_n, err_n, st;
  logic [31:0] fs_n, ttl_n, ip_n;
  logic [15:0] sk_n, al_n, ty_n, rl_n, pr_n, idx;
  logic        emit, inrange;
  logic [31:0] sh;

  always_comb begin
    off_n = byte_offset; ph_n = parse_phase; fs_n = field_shift; sk_n = skip_count;
    al_n = answers_left; err_n = error_code; ty_n = cur_type; ttl_n = cur_ttl;
    rl_n = cur_rdlen; pr_n = cur_prio; ip_n = cur_ip; emit = 1'b0;
    inrange = byte_offset < OffW'(MaxPacketBytes);
    sh = {field_shift[23:0], data_byte};
    idx = cur_rdlen - skip_count;
    if (inrange) begin
      off_n = byte_offset + 1'b1;
      case (parse_phase)
        PH_HEADER: begin
          fs_n = sh;
          if (byte_offset == 1 && sh[15:0] != expected_id) begin
            err_n = ST_ID; ph_n = PH_DRAIN;
          end else if (byte_offset == 3 && data_byte[3:0] != 4'd0) begin
            err_n = ST_RCODE; ph_n = PH_DRAIN;
          end else if (byte_offset == 5 && sh[15:0] != 16'd1) begin
            err_n = ST_QCOUNT; ph_n = PH_DRAIN;
          end else if (byte_offset == 7) begin
            al_n = sh[15:0];
          end else if (byte_offset == 11) begin
            ph_n = PH_QNAME;
          end
        end
        PH_QNAME: begin
          if (data_byte == 8'd0) begin
            ph_n = PH_QFIXED; sk_n = '0; fs_n = '0;
          end
        end
        PH_QFIXED: begin
          fs_n = sh; sk_n = skip_count + 1'b1;
          if (sk_n == 16'd4) begin
            sk_n = '0;
            if (sh[15:0] != CLASS_IN) begin
              err_n = ST_CLASS; ph_n = PH_DRAIN;
            end else if (sh[31:16] != expected_type) begin
              err_n = ST_TYPE; ph_n = PH_DRAIN;
            end else if (answers_left > max_answers) begin
              err_n = ST_COUNT; ph_n = PH_DRAIN;
            end else if (answers_left == 16'd0) begin
              ph_n = PH_DONE;
            end else begin
              ph_n = PH_ALEN;
            end
          end
        end
        PH_ALEN: begin
          if (data_byte == 8'd0) begin
            ph_n = PH_AFIXED; sk_n = '0;
          end else if (data_byte[7:6] == 2'b11) begin
            ph_n = PH_APTR;
          end else begin
            sk_n = {8'd0, data_byte}; ph_n = PH_ASKIP;
          end
        end
        PH_ASKIP: begin
          sk_n = skip_count - 1'b1;
          if (sk_n == 16'd0) ph_n = PH_ALEN;
        end
        PH_APTR: begin
          ph_n = PH_AFIXED; sk_n = '0;
        end
        PH_AFIXED: begin
          fs_n = sh; sk_n = skip_count + 1'b1;
          if (skip_count == 16'd1) ty_n = sh[15:0];
          else if (skip_count == 16'd7) ttl_n = sh;
          else if (skip_count == 16'd9) begin
            rl_n = sh[15:0]; ip_n = '0; pr_n = '0;
            if (sh[15:0] == 16'd0) emit = 1'b1;
            else begin
              sk_n = sh[15:0]; ph_n = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          if (idx < 16'd4) ip_n = {cur_ip[23:0], data_byte};
          if (idx < 16'd2) pr_n = {cur_prio[7:0], data_byte};
          sk_n = skip_count - 1'b1;
          if (sk_n == 16'd0) emit = 1'b1;
        end
        default: ;
      endcase
      if (emit) begin
        al_n = answers_left - 1'b1;
        ph_n = (al_n == 16'd0) ? PH_DONE : PH_ALEN;
        sk_n = '0;
      end
    end
    if (off_n < OffW'(12))           st = ST_SHORT;
    else if (err_n != ST_OK)         st = err_n;
    else if (ph_n == PH_DONE)        st = ST_OK;
    else if (ph_n == PH_QNAME)       st = ST_QNAME;
    else if (ph_n == PH_HEADER)      st = ST_SHORT;
    else                             st = ST_TRUNC;
  end

  always_comb begin
    rec_a = '0;
    rec_a.rtype = ty_n; rec_a.ttl = ttl_n; rec_a.ip = ip_n;
    rec_a.prio = pr_n; rec_a.rdlen = rl_n; rec_a.pos = byte_offset[8:0];
    rec_s = '0;
    rec_s.is_status = 1'b1; rec_s.status = st;
  end
  assign rec_valid = take && emit;
  assign sts_valid = take && end_of_packet;

  always_ff @(posedge clk) begin
    if (rst || (take && end_of_packet)) begin
      byte_offset <= '0; parse_phase <= PH_HEADER; field_shift <= '0;
      skip_count <= '0; answers_left <= '0; error_code <= '0; cur_type <= '0;
      cur_ttl <= '0; cur_rdlen <= '0; cur_prio <= '0; cur_ip <= '0;
    end else if (take) begin
      byte_offset <= off_n; parse_phase <= ph_n; field_shift <= fs_n;
      skip_count <= sk_n; answers_left <= al_n; error_code <= err_n;
      cur_type <= ty_n; cur_ttl <= ttl_n; cur_rdlen <= rl_n;
      cur_prio <= pr_n; cur_ip <= ip_n;
    end
  end

`include "assert_macros.svh"
  `CHK(a_drain_err, (parse_phase == PH_DRAIN) |-> (error_code != ST_OK), "drain without error")
  `CHK(a_emit_phase, rec_valid |-> (parse_phase == PH_AFIXED || parse_phase == PH_RDATA), "bad emit")
  `CHK_INV(a_off_max, byte_offset <= OffW'(MaxPacketBytes), "offset overrun")
endmodule
`default_nettype wire

>>> sv/drp_back.sv
// Record queue and result formatter: buffers raw records, shapes result words.
// Depends on drp_pkg.
`default_nettype none
module drp_back import drp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_a,
  input  rec_t      din_a,
  input  wire logic wr_s,
  input  rec_t      din_s,
  output logic      room,
  output logic      nonempty,
  input  wire logic rd,
  output res_t      dout
);
  localparam int AW = $clog2(QDepth);
  rec_t mem [QDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  rec_t h;
  logic [15:0] st;
  logic isa, ismx, mxok;

  assign room = cnt <= (AW+1)'(QDepth - 2);
  assign nonempty = cnt != '0;

  always_ff @(posedge clk) begin
    if (wr_a && wr_s) begin
      mem[wp] <= din_a; mem[wp + 1'b1] <= din_s;
    end else if (wr_a) mem[wp] <= din_a;
    else if (wr_s) mem[wp] <= din_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp <= wp + AW'({1'b0, wr_a} + {1'b0, wr_s});
      if (rd && nonempty) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'({1'b0, wr_a} + {1'b0, wr_s}) - (AW+1)'(rd && nonempty);
    end
  end

  always_comb begin
    h = mem[rp];
    isa = h.rtype == TYPE_A && h.rdlen >= 16'd4;
    ismx = h.rtype == TYPE_MX;
    mxok = ismx && h.rdlen >= 16'd2;
    st = 16'(h.pos) + 16'd1 - h.rdlen + (mxok ? 16'd2 : 16'd0);
    dout = '0;
    if (h.is_status) begin
      dout.is_status = 1'b1; dout.status = h.status; dout.last = 1'b1;
    end else begin
      dout.record_type = h.rtype; dout.time_to_live = h.ttl;
      dout.ipv4_address = isa ? h.ip : 32'd0;
      dout.mx_priority = mxok ? h.prio : 16'd0;
      dout.rdata_offset = st[8:0];
      dout.rdata_length = ismx ? (mxok ? h.rdlen - 16'd2 : 16'd0) : h.rdlen;
    end
  end

`include "assert_macros.svh"
  `CHK(a_no_over, (wr_a || wr_s) |-> (cnt <= (AW+1)'(QDepth - 2)), "queue overflow")
  `CHK_INV(a_cnt_rng, cnt <= (AW+1)'(QDepth), "count out of range")
  `CHK(a_status_last, (nonempty && h.is_status) |-> dout.last, "status without last")
endmodule
`default_nettype wire

>>> sv/dns_response_parser_core.sv
// Channel    | handshake        | payload
// input      | push / full      | data_byte, end_of_packet
// result     | empty / pop      | is_status .. last
// config     | cfg_valid/ready  | cfg_index, cfg_data
// One byte per cycle while full is low; the front parser decides each byte combinationally.
// Results are registered in the record queue and reach the ports from its head.
// full rises when the four-entry record queue has under two free slots.
// Synchronous reset clears parser state and queue and sets config registers to defaults; no clearing pass.
// Top level of the DNS response parser; depends on drp_pkg, drp_front, drp_back.
`default_nettype none
module dns_response_parser_core import drp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_packet,
  output logic             empty,
  input  wire logic        pop,
  output logic             is_status,
  output logic [15:0]      record_type,
  output logic [31:0]      time_to_live,
  output logic [31:0]      ipv4_address,
  output logic [15:0]      mx_priority,
  output logic [8:0]       rdata_offset,
  output logic [15:0]      rdata_length,
  output logic [3:0]       status,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [15:0] expected_id, expected_type, max_answers;
  logic take, ra_v, rs_v, room, nonempty;
  rec_t ra, rs;
  res_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0; expected_type <= 16'd1; max_answers <= 16'd20;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ID:    expected_id <= cfg_data;
        REG_TYPE:  expected_type <= cfg_data;
        REG_MAXAN: max_answers <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = !room;
  assign take = push && room;
  assign empty = !nonempty;

  drp_front u_front (
    .clk, .rst, .take, .data_byte, .end_of_packet, .expected_id, .expected_type,
    .max_answers, .rec_valid(ra_v), .rec_a(ra), .sts_valid(rs_v), .rec_s(rs)
  );

  drp_back u_back (
    .clk, .rst, .wr_a(ra_v), .din_a(ra), .wr_s(rs_v), .din_s(rs), .room,
    .nonempty, .rd(pop), .dout(res)
  );

  assign is_status = res.is_status;
  assign record_type = res.record_type;
  assign time_to_live = res.time_to_live;
  assign ipv4_address = res.ipv4_address;
  assign mx_priority = res.mx_priority;
  assign rdata_offset = res.rdata_offset;
  assign rdata_length = res.rdata_length;
  assign status = res.status;
  assign last = res.last;
endmodule
`default_nettype wire
